[src/lru_key_value_cache_defines.svh]
// assertion macros shared by the lru key-value cache rtl
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

`ifndef SYNTHESIS
`define LKV_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("lru cache check failed");
`define LKV_NEVER(lbl, clk, rst_n, cond) \
	`LKV_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define LKV_ASSERT(lbl, clk, rst_n, prop)
`define LKV_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

[src/lkv_pkg.sv]
// types and constants of the lru key-value cache
package lkv_pkg;

	localparam int DATA_W = 32;
	localparam int CAP_W = 5;
	localparam int ADDR_W = 3;
	localparam int REG_IDX_W = ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_CAPACITY = '0;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic [DATA_W-1:0] READ_MISS = 32'hFFFF_FFFF;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t opcode;
		logic signed [DATA_W-1:0] lookup_key;
		logic signed [DATA_W-1:0] store_value;
	} req_t;

	typedef struct packed {
		logic hit;
		logic signed [DATA_W-1:0] read_value;
		logic evicted;
		logic signed [DATA_W-1:0] evicted_key;
	} rsp_t;

endpackage

[src/lkv_if.sv]
// request and result channels of the lru key-value cache
interface lkv_req_if;
	logic valid;
	logic ready;
	logic opcode;
	logic signed [31:0] lookup_key;
	logic signed [31:0] store_value;

	modport source(output valid, opcode, lookup_key, store_value, input ready);
	modport sink(input valid, opcode, lookup_key, store_value, output ready);
endinterface

interface lkv_rsp_if;
	logic valid;
	logic ready;
	logic hit;
	logic signed [31:0] read_value;
	logic evicted;
	logic signed [31:0] evicted_key;

	modport source(output valid, hit, read_value, evicted, evicted_key, input ready);
	modport sink(input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

[src/lkv_cfg.sv]
// apb register block holding the capacity register
module lkv_cfg
	import lkv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output logic [CAP_W-1:0]  capacity
);

	logic [CAP_W-1:0] capacity_q;
	logic             sel_cap;

	assign pready   = 1'b1;
	assign sel_cap  = paddr[ADDR_W-1:2] == REG_CAPACITY;
	assign capacity = capacity_q;
	assign prdata   = sel_cap ? 32'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && sel_cap) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

endmodule

[src/lkv_table.sv]
// entry table: parallel key match, lru ranks and per-request update
`include "lru_key_value_cache_defines.svh"

module lkv_table
	import lkv_pkg::*;
#(
	parameter int ENTRIES  = 16,
	parameter int KEY_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             commit,
	input  req_t             req,
	input  logic [CAP_W-1:0] capacity,
	output rsp_t             rsp
);

	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int KIN_W  = (KEY_BITS < DATA_W) ? KEY_BITS : DATA_W;

	logic [KEY_BITS-1:0] key_q   [ENTRIES];
	logic [DATA_W-1:0]   value_q [ENTRIES];
	logic [RANK_W-1:0]   rank_q  [ENTRIES];
	logic [ENTRIES-1:0]  valid_q;
	logic [CNT_W-1:0]    count_q;

	logic [KEY_BITS-1:0] req_key;
	logic                is_put;
	logic [ENTRIES-1:0]  found_oh;
	logic [ENTRIES-1:0]  victim_oh;
	logic [ENTRIES-1:0]  free_oh;
	logic [ENTRIES-1:0]  slot_oh;
	logic [ENTRIES-1:0]  age;
	logic                hit;
	logic                evict;
	logic                insert;
	logic                update;
	logic [CNT_W-1:0]    count_m1;
	logic [CMP_W-1:0]    cap_eff;
	logic [DATA_W-1:0]   found_value;
	logic [KEY_BITS-1:0] victim_key;
	logic [RANK_W-1:0]   slot_rank;
	logic [DATA_W-1:0]   victim_key_out;

	assign req_key  = KEY_BITS'(req.lookup_key[KIN_W-1:0]);
	assign is_put   = req.opcode == OP_PUT;
	assign count_m1 = count_q - CNT_W'(1);
	assign cap_eff  = (capacity == '0) ? CMP_W'(1) : CMP_W'(capacity);

	// the least recent valid entry always holds rank count-1
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			found_oh[i]  = valid_q[i] && (key_q[i] == req_key);
			victim_oh[i] = valid_q[i] && (rank_q[i] == count_m1[RANK_W-1:0]);
		end
	end

	// lowest free slot
	assign free_oh = ~valid_q & (valid_q + ENTRIES'(1));

	assign hit    = |found_oh;
	assign evict  = is_put && !hit &&
		((CMP_W'(count_q) >= cap_eff) || (count_q == CNT_W'(ENTRIES)));
	assign insert = is_put && !hit && !evict;
	assign update = hit || is_put;
	assign slot_oh = hit ? found_oh : (evict ? victim_oh : free_oh);

	always_comb begin
		found_value = '0;
		victim_key  = '0;
		slot_rank   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (found_oh[i]) begin
				found_value = found_value | value_q[i];
			end
			if (victim_oh[i]) begin
				victim_key = victim_key | key_q[i];
			end
			if (slot_oh[i]) begin
				slot_rank = slot_rank | rank_q[i];
			end
		end
	end

	// every valid entry more recent than the promoted one ages by one
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			age[i] = update && valid_q[i] && !slot_oh[i] && (insert || (rank_q[i] < slot_rank));
		end
	end

	// evicted key sign-extended from the stored key width
	for (genvar b = 0; b < DATA_W; b++) begin : g_key_out
		if (b < KEY_BITS) begin : g_bit
			assign victim_key_out[b] = victim_key[b];
		end else begin : g_ext
			assign victim_key_out[b] = victim_key[KEY_BITS-1];
		end
	end

	always_comb begin
		rsp.hit         = hit;
		rsp.evicted     = evict;
		rsp.evicted_key = evict ? $signed(victim_key_out) : '0;
		if (is_put) begin
			rsp.read_value = '0;
		end else if (hit) begin
			rsp.read_value = $signed(found_value);
		end else begin
			rsp.read_value = $signed(READ_MISS);
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (is_put && slot_oh[i]) begin
					key_q[i]   <= req_key;
					value_q[i] <= req.store_value;
				end
				if (update && slot_oh[i]) begin
					rank_q[i] <= '0;
				end else if (age[i]) begin
					rank_q[i] <= rank_q[i] + RANK_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (commit && insert) begin
			valid_q <= valid_q | free_oh;
			count_q <= count_q + CNT_W'(1);
		end
	end

	`LKV_ASSERT(a_count_matches_valid, clk, arst_n, ($countones(valid_q) == int'(count_q)))
	`LKV_ASSERT(a_single_match, clk, arst_n, $onehot0(found_oh))
	`LKV_ASSERT(a_evict_keeps_count, clk, arst_n, (commit && evict |=> $stable(count_q)))
	`LKV_NEVER(a_evict_no_victim, clk, arst_n, (commit && evict && !$onehot(victim_oh)))

endmodule

[src/lru_key_value_cache.sv]
// lru key-value cache: request channel, entry table, result register, apb registers
//
// Requests arrive on req (valid/ready): a get (opcode 0) looks up lookup_key,
// a put (opcode 1) stores store_value under lookup_key. Every request gives
// exactly one result on rsp: hit, read_value, evicted and evicted_key.
// Up to ENTRIES pairs are held, fully associative, with least-recently-used
// replacement once the number of valid entries reaches capacity_in_use.
// An accepted request is registered, then matched against all entries in
// parallel; the result and the updated table are written together when the
// request moves on to the result register, which a stalled rsp can delay.
// One request per cycle is sustained while rsp is not stalled; the table update,
// done once per request, sets that rate, as each request sees the table left by
// the one before. When rsp is stalled the result and the next request are held
// and req.ready drops only if a request is already waiting behind the result.
// Reset clears all valid marks and sets capacity_in_use to 16; no clearing pass
// is needed, so a request is accepted right after reset. The capacity register
// is at apb byte address 0; the user writes it only while idle (not enforced).
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache
	import lkv_pkg::*;
#(
	parameter int ENTRIES  = 16,
	parameter int KEY_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	lkv_req_if.sink           req,
	lkv_rsp_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic             valid_s1;
	req_t             req_s1;
	logic             valid_s2;
	rsp_t             rsp_s2;
	rsp_t             rsp_d;
	logic             advance;
	logic [CAP_W-1:0] capacity;

	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.opcode      <= opcode_t'(req.opcode);
			req_s1.lookup_key  <= req.lookup_key;
			req_s1.store_value <= req.store_value;
		end
	end

	lkv_table #(
		.ENTRIES (ENTRIES),
		.KEY_BITS(KEY_BITS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (advance),
		.req     (req_s1),
		.capacity(capacity),
		.rsp     (rsp_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.hit         = rsp_s2.hit;
	assign rsp.read_value  = rsp_s2.read_value;
	assign rsp.evicted     = rsp_s2.evicted;
	assign rsp.evicted_key = rsp_s2.evicted_key;

	lkv_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.capacity(capacity)
	);

	`LKV_ASSERT(a_advance_fills_out, clk, arst_n, (advance |=> valid_s2))
	`LKV_ASSERT(a_stall_only_when_full, clk, arst_n, (!req.ready |-> (valid_s1 && valid_s2 && !rsp.ready)))
	`LKV_ASSERT(a_waiting_item_kept, clk, arst_n, (valid_s1 && !advance |=> (valid_s1 && $stable(req_s1))))

endmodule

[tb/testbench.sv]
// testbench of the lru key-value cache: directed table then random get/put traffic vs predictor
module testbench
	import lkv_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 16;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 1'b1;

	typedef struct {
		bit is_cfg;
		logic [REG_IDX_W-1:0] reg_idx;
		logic [31:0] reg_data;
		opcode_t op;
		logic [31:0] key;
		logic [31:0] value;
		bit known;
		rsp_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	lkv_req_if req_ch();
	lkv_rsp_if rsp_ch();

	lru_key_value_cache i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	// shadow of the entry table and the capacity register
	logic [31:0] slot_key[TABLE_DEPTH];
	logic [31:0] slot_val[TABLE_DEPTH];
	bit slot_live[TABLE_DEPTH];
	int unsigned slot_age[TABLE_DEPTH];
	logic [CAP_W-1:0] cap_reg;

	rsp_t outcome_q[$];
	plan_row_t plan[$];
	int mismatches = 0;
	bit calm = 1'b0;

	function automatic int unsigned held_limit();
		if (cap_reg == 0)
			return 1;
		if (cap_reg > TABLE_DEPTH)
			return TABLE_DEPTH;
		return cap_reg;
	endfunction

	// make a slot most recent; live entries more recent than from_rank age by one
	function automatic void age_up(int slot, int unsigned from_rank);
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (slot_live[i] && i != slot && slot_age[i] < from_rank)
				slot_age[i]++;
		slot_age[slot] = 0;
	endfunction

	function automatic rsp_t lookup_and_update(opcode_t op, logic [31:0] key, logic [31:0] val);
		rsp_t r;
		int found, free_slot, victim;
		int unsigned count, worst;
		found = -1;
		free_slot = -1;
		victim = -1;
		count = 0;
		worst = 0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (slot_live[i]) begin
				count++;
				if (slot_key[i] == key)
					found = i;
				if (victim < 0 || slot_age[i] > worst) begin
					victim = i;
					worst = slot_age[i];
				end
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		r = '0;
		r.hit = (found >= 0);
		if (op == OP_GET) begin
			if (found >= 0) begin
				r.read_value = slot_val[found];
				age_up(found, slot_age[found]);
			end else begin
				r.read_value = READ_MISS;
			end
			return r;
		end
		if (found >= 0) begin
			slot_val[found] = val;
			age_up(found, slot_age[found]);
		end else if (count >= held_limit() || free_slot < 0) begin
			r.evicted = 1'b1;
			r.evicted_key = slot_key[victim];
			slot_key[victim] = key;
			slot_val[victim] = val;
			age_up(victim, worst);
		end else begin
			slot_live[free_slot] = 1'b1;
			slot_key[free_slot] = key;
			slot_val[free_slot] = val;
			age_up(free_slot, TABLE_DEPTH);
		end
		return r;
	endfunction

	function automatic void plan_req(opcode_t op, logic [31:0] key, logic [31:0] value,
			bit known, logic hit, logic [31:0] rd, logic ev, logic [31:0] ev_key);
		plan_row_t row;
		row = '{op: OP_GET, default: '0};
		row.op = op;
		row.key = key;
		row.value = value;
		row.known = known;
		row.want.hit = hit;
		row.want.read_value = rd;
		row.want.evicted = ev;
		row.want.evicted_key = ev_key;
		plan.push_back(row);
	endfunction

	function automatic void plan_cfg(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
		plan_row_t row;
		row = '{op: OP_GET, default: '0};
		row.is_cfg = 1'b1;
		row.reg_idx = idx;
		row.reg_data = data;
		plan.push_back(row);
	endfunction

	task automatic send_request(opcode_t op, logic [31:0] key, logic [31:0] value);
		while (!calm && $urandom_range(99) < 6) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.lookup_key <= key;
		req_ch.store_value <= value;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		outcome_q.push_back(lookup_and_update(op, key, value));
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_CAPACITY)
			cap_reg = data[CAP_W-1:0];
		@(posedge clk);
	endtask

	always @(posedge clk)
		rsp_ch.ready <= calm || ($urandom_range(99) >= 6);

	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (outcome_q.size() == 0) begin
				$error("result item with no request outstanding");
				mismatches++;
			end else begin
				want = outcome_q.pop_front();
				if (rsp_ch.hit !== want.hit) begin
					$error("hit: expected %0b, got %0b", want.hit, rsp_ch.hit);
					mismatches++;
				end
				if (rsp_ch.read_value !== want.read_value) begin
					$error("read_value: expected %h, got %h", want.read_value,
						rsp_ch.read_value);
					mismatches++;
				end
				if (rsp_ch.evicted !== want.evicted) begin
					$error("evicted: expected %0b, got %0b", want.evicted, rsp_ch.evicted);
					mismatches++;
				end
				if (rsp_ch.evicted_key !== want.evicted_key) begin
					$error("evicted_key: expected %h, got %h", want.evicted_key,
						rsp_ch.evicted_key);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		int cap_plan[10];
		logic [31:0] key_pool[$];
		logic [31:0] key, data;
		int unsigned target;
		opcode_t op;

		cap_plan = '{16, 1, 31, 0, 5, 2, 20, 8, 3, 16};
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_GET;
		req_ch.lookup_key = '0;
		req_ch.store_value = '0;
		rsp_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			slot_key[i] = '0;
			slot_val[i] = '0;
			slot_live[i] = 1'b0;
			slot_age[i] = 0;
		end
		cap_reg = CAP_RESET;

		// directed: empty table, key extremes, update, capacity corners
		plan_req(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1, 0, READ_MISS, 0, 0);
		plan_req(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 0, 0, 0);
		plan_req(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0, 0, 0);
		plan_req(OP_GET, 32'h8000_0000, 32'h0000_0000, 1, 1, 32'h7FFF_FFFF, 0, 0);
		plan_req(OP_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1, 0, 0, 0);
		plan_req(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1, 1, 32'hFFFF_FFFF, 0, 0);
		plan_req(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1, 0, READ_MISS, 0, 0);
		// capacity zero acts as one, below the two entries already held
		plan_cfg(REG_CAPACITY, 32'h0000_0000);
		plan_req(OP_PUT, 32'h0000_0001, 32'h0000_0005, 1, 0, 0, 1, 32'h8000_0000);
		plan_req(OP_PUT, 32'h0000_0002, 32'h1234_5678, 1, 0, 0, 1, 32'h7FFF_FFFF);
		plan_req(OP_GET, 32'h0000_0001, 32'h0000_0000, 1, 1, 32'h0000_0005, 0, 0);
		// capacity above the table saturates; a write past the register list is dropped
		plan_cfg(REG_CAPACITY, 32'h0000_001F);
		plan_cfg(REG_UNUSED, 32'hFFFF_FFFF);
		plan_req(OP_PUT, 32'h0000_0000, 32'h8000_0000, 1, 0, 0, 0, 0);
		plan_req(OP_GET, 32'h0000_0000, 32'h0000_0000, 1, 1, 32'h8000_0000, 0, 0);
		// upper data bits ignored: capacity two
		plan_cfg(REG_CAPACITY, 32'hFFFF_FFE2);
		plan_req(OP_PUT, 32'h0000_0003, 32'h0000_0007, 0, 0, 0, 0, 0);
		plan_req(OP_GET, 32'h0000_0002, 32'h0000_0000, 0, 0, 0, 0, 0);
		plan_req(OP_GET, 32'h0000_0003, 32'h0000_0000, 0, 0, 0, 0, 0);
		plan_req(OP_PUT, 32'h0000_0001, 32'h0000_0000, 0, 0, 0, 0, 0);
		plan_cfg(REG_CAPACITY, 32'h0000_0010);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[n]) begin
			if (plan[n].is_cfg) begin
				drain();
				write_reg(plan[n].reg_idx, plan[n].reg_data);
			end else begin
				send_request(plan[n].op, plan[n].key, plan[n].value);
				if (plan[n].known) begin
					void'(outcome_q.pop_back());
					outcome_q.push_back(plan[n].want);
				end
			end
		end

		key_pool = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
		foreach (cap_plan[p]) begin
			drain();
			data = $urandom;
			data[CAP_W-1:0] = cap_plan[p][CAP_W-1:0];
			write_reg(REG_CAPACITY, data);
			if (p % 3 == 1)
				write_reg(REG_UNUSED, $urandom);
			calm = (p == 6);
			// pool a little larger than the capacity so both hits and evictions occur
			target = held_limit() + $urandom_range(1, 5);
			while (key_pool.size() > target)
				key_pool.delete($urandom_range(key_pool.size() - 1));
			while (key_pool.size() < target)
				key_pool.push_back($urandom);
			repeat (120) begin
				op = opcode_t'($urandom_range(1));
				if ($urandom_range(19) == 0)
					key = $urandom;
				else
					key = key_pool[$urandom_range(key_pool.size() - 1)];
				send_request(op, key, $urandom);
			end
		end
		calm = 1'b0;

		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin : watchdog
		#(5_000_000);
		$display("Regression FAIL");
		$finish;
	end

endmodule
